// ----- hdl/bpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfa_pkg
// shared types and constants of the bitmap page frame allocator
// ----------------------------------------------------------------------------
package bpfa_pkg;

   // fixed field widths
   localparam int PADDR_W      = 48;  // physical address
   localparam int PAGES_W      = 13;  // page count of one region
   localparam int COUNT_W      = 2;   // region count register
   localparam int REGION_SLOTS = 3;   // region slots in the register map
   localparam int START_W      = 15;  // running page number over all slots

   // bitmap memory word
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_PAGES_0 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE_1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_PAGES_1 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE_2 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_PAGES_2 = 3'd6;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_IDX [REGION_SLOTS] =
      '{CSR_REGION_BASE_0, CSR_REGION_BASE_1, CSR_REGION_BASE_2};
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGES_IDX [REGION_SLOTS] =
      '{CSR_REGION_PAGES_0, CSR_REGION_PAGES_1, CSR_REGION_PAGES_2};

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } bpfa_op_type;

   typedef enum logic [1:0] {
      STATUS_ALLOCATED    = 2'd0,
      STATUS_NO_FREE_PAGE = 2'd1,
      STATUS_FREED        = 2'd2,
      STATUS_FREE_IGNORED = 2'd3
   } bpfa_status_type;

   typedef struct packed {
      bpfa_op_type        operation;
      logic [PADDR_W-1:0] page_address;
   } bpfa_req_type;

   typedef struct packed {
      logic [PADDR_W-1:0] result_address;
      bpfa_status_type    status;
   } bpfa_rsp_type;

   // region layout seen by the engine
   typedef struct packed {
      logic [COUNT_W-1:0]                    count;
      logic [REGION_SLOTS-1:0][PADDR_W-1:0]  base;
      logic [REGION_SLOTS-1:0][PAGES_W-1:0]  pages;
      logic [REGION_SLOTS-1:0][START_W-1:0]  start;
      logic [START_W-1:0]                    total;
   } bpfa_layout_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACHECK,
      ST_AREGION,
      ST_AADDR,
      ST_FMATCH,
      ST_FIDX,
      ST_FWRITE,
      ST_RESP
   } bpfa_state_type;

endpackage

// ----- hdl/bpfa_ram.sv -----
// ----------------------------------------------------------------------------
// bpfa_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module bpfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bpfa_csr.sv -----
// ----------------------------------------------------------------------------
// bpfa_csr
// region configuration registers and derived page numbering
// ----------------------------------------------------------------------------
module bpfa_csr #(
   parameter int MAX_REGIONS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bpfa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bpfa_pkg::bpfa_layout_type           layout
);

   import bpfa_pkg::*;

   logic [COUNT_W-1:0]                   count_ff;
   logic [COUNT_W-1:0]                   count_in;
   logic [COUNT_W-1:0]                   active;
   logic [REGION_SLOTS-1:0][PADDR_W-1:0] base;
   logic [REGION_SLOTS-1:0][PAGES_W-1:0] pages;

   always_comb begin
      count_in = count_ff;
      if (csr_we && csr_index == CSR_REGION_COUNT) begin
         count_in = csr_wdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar s = 0; s < REGION_SLOTS; s++) begin : g_slot
      if (s < MAX_REGIONS) begin : g_used
         logic [PADDR_W-1:0] base_ff;
         logic [PADDR_W-1:0] base_in;
         logic [PAGES_W-1:0] pages_ff;
         logic [PAGES_W-1:0] pages_in;

         always_comb begin
            base_in  = base_ff;
            pages_in = pages_ff;
            if (csr_we && csr_index == CSR_BASE_IDX[s]) begin
               base_in = csr_wdata[PADDR_W-1:0];
            end
            if (csr_we && csr_index == CSR_PAGES_IDX[s]) begin
               pages_in = csr_wdata[PAGES_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               base_ff  <= '0;
               pages_ff <= '0;
            end else begin
               base_ff  <= base_in;
               pages_ff <= pages_in;
            end
         end

         assign base[s]  = base_ff;
         assign pages[s] = pages_ff;
      end else begin : g_unused
         assign base[s]  = '0;
         assign pages[s] = '0;
      end
   end

   // clamp the count to the slots that exist
   assign active = (count_ff > COUNT_W'(MAX_REGIONS)) ? COUNT_W'(MAX_REGIONS) : count_ff;

   always_comb begin
      layout.count    = active;
      layout.base     = base;
      layout.pages    = pages;
      layout.start[0] = '0;
      layout.start[1] = START_W'(pages[0]);
      layout.start[2] = START_W'(pages[0]) + START_W'(pages[1]);
      layout.total    = ((active > 2'd0) ? START_W'(pages[0]) : '0)
                      + ((active > 2'd1) ? START_W'(pages[1]) : '0)
                      + ((active > 2'd2) ? START_W'(pages[2]) : '0);
   end

endmodule

// ----- hdl/bpfa_find.sv -----
// ----------------------------------------------------------------------------
// bpfa_find
// lowest clear bit of one bitmap word under a mask
// ----------------------------------------------------------------------------
module bpfa_find (
   input  logic [bpfa_pkg::WORD_W-1:0] word_bits,
   input  logic [bpfa_pkg::WORD_W-1:0] mask_bits,
   output logic                        found,
   output logic [bpfa_pkg::BIT_W-1:0]  position
);

   import bpfa_pkg::*;

   logic [WORD_W-1:0] avail;
   logic [WORD_W-1:0] lowest;

   always_comb begin
      avail  = ~word_bits & mask_bits;
      // isolate the lowest set bit, then encode the one-hot vector
      lowest = avail & (~avail + WORD_W'(1));
      found  = |avail;
      position = '0;
      for (int k = 0; k < WORD_W; k++) begin
         if (lowest[k]) begin
            position = position | BIT_W'(k);
         end
      end
   end

endmodule

// ----- hdl/bitmap_page_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// page frame allocator over up to three regions with a bitmap in ram
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   bpfa_req_type (operation, page_address)
//  rsp      out  rsp_valid/rsp_stall   bpfa_rsp_type (result_address, status)
//  csr      in   csr_we                csr_index, csr_wdata
//
//  one item at a time: a granted allocate scans the bitmap words, starting from
//  the lowest word that may hold a free page; a freed page compares the regions,
//  one a cycle; refused and ignored items finish sooner
//  after reset a clearing pass writes all DEPTH bitmap words (128 at the default
//  size), one per cycle, with req_stall high
//  a finished item waits in its last state only while the response register is stalled
//
module bitmap_page_frame_allocator_core #(
   parameter int TOTAL_PAGES = 4096,
   parameter int PAGE_BYTES  = 4096,  // power of two
   parameter int MAX_REGIONS = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bpfa_pkg::bpfa_req_type            req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bpfa_pkg::bpfa_rsp_type            rsp_data,
   // configuration writes
   input  logic                              csr_we,
   input  logic [bpfa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import bpfa_pkg::*;

   // bitmap geometry
   localparam int DEPTH      = (TOTAL_PAGES + WORD_W - 1) / WORD_W;
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int OFS_W      = PADDR_W - PAGE_SHIFT;
   localparam int TP_W       = $clog2(TOTAL_PAGES + 1);
   localparam int IDX_A      = (AW + BIT_W > START_W) ? AW + BIT_W : START_W;
   localparam int IDX_W      = (TP_W > IDX_A) ? TP_W : IDX_A;

   bpfa_layout_type layout;

   // state and datapath registers
   bpfa_state_type     state_ff, state_in;
   logic [AW-1:0]      word_ff, word_in;
   logic [AW-1:0]      hint_ff, hint_in;     // words below this one are full
   logic [AW-1:0]      clr_ff, clr_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PAGES_W-1:0] j_ff, j_in;
   logic [1:0]         r_ff, r_in;
   logic [PADDR_W-1:0] target_ff, target_in;
   logic [PADDR_W-1:0] res_addr_ff, res_addr_in;
   bpfa_status_type    res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bpfa_rsp_type       rsp_data_ff, rsp_data_in;

   // ram ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   // scan range
   logic [IDX_W-1:0]  limit;
   logic [IDX_W-1:0]  limit_m1;
   logic              limit_zero;
   logic [AW-1:0]     last_word;
   logic [WORD_W-1:0] tail_mask;
   logic [WORD_W-1:0] scan_mask;
   logic              found;
   logic [BIT_W-1:0]  found_bit;

   // free path
   logic [PADDR_W-1:0] diff;
   logic [IDX_W-1:0]   free_idx;

   bpfa_csr #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .layout    (layout)
   );

   bpfa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bpfa_find u_find (
      .word_bits (rd_data),
      .mask_bits (scan_mask),
      .found     (found),
      .position  (found_bit)
   );

   // pages past the bitmap are never handed out
   assign limit = (IDX_W'(layout.total) < IDX_W'(TOTAL_PAGES)) ?
                  IDX_W'(layout.total) : IDX_W'(TOTAL_PAGES);
   assign limit_m1   = limit - IDX_W'(1);
   assign limit_zero = (limit == '0);
   assign last_word  = limit_m1[AW+BIT_W-1:BIT_W];

   always_comb begin
      for (int k = 0; k < WORD_W; k++) begin
         tail_mask[k] = (BIT_W'(k) <= limit_m1[BIT_W-1:0]);
      end
   end

   // only the last word of the range is cut short
   assign scan_mask = (word_ff == last_word) ? tail_mask : '1;

   assign diff     = target_ff - layout.base[r_ff];
   assign free_idx = IDX_W'(layout.start[r_ff]) + IDX_W'(j_ff);

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      hint_in       = hint_ff;
      clr_in        = clr_ff;
      bit_in        = bit_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      target_in     = target_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = word_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep zeros through the bitmap after reset
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               res_addr_in = '0;
               if (req_data.operation == OP_ALLOC) begin
                  if (limit_zero || hint_ff > last_word) begin
                     res_status_in = STATUS_NO_FREE_PAGE;
                     state_in      = ST_RESP;
                  end else begin
                     word_in  = hint_ff;
                     rd_en    = 1'b1;
                     rd_addr  = hint_ff;
                     state_in = ST_ACHECK;
                  end
               end else begin
                  if (req_data.page_address[PAGE_SHIFT-1:0] != '0) begin
                     res_status_in = STATUS_FREE_IGNORED;
                     state_in      = ST_RESP;
                  end else begin
                     target_in = req_data.page_address;
                     r_in      = '0;
                     state_in  = ST_FMATCH;
                  end
               end
            end
         end

         ST_ACHECK: begin
            // one word per cycle, next read issued while this one is checked
            if (found) begin
               idx_in   = IDX_W'({word_ff, found_bit});
               wr_en    = 1'b1;
               wr_addr  = word_ff;
               wr_data  = rd_data | (WORD_W'(1) << found_bit);
               hint_in  = word_ff;
               state_in = ST_AREGION;
            end else if (word_ff == last_word) begin
               res_status_in = STATUS_NO_FREE_PAGE;
               state_in      = ST_RESP;
            end else begin
               word_in = word_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = word_ff + AW'(1);
            end
         end

         ST_AREGION: begin
            // page number back to region and page within region
            priority if (idx_ff < IDX_W'(layout.start[1])) begin
               r_in = 2'd0;
               j_in = PAGES_W'(idx_ff);
            end else if (idx_ff < IDX_W'(layout.start[2])) begin
               r_in = 2'd1;
               j_in = PAGES_W'(idx_ff - IDX_W'(layout.start[1]));
            end else begin
               r_in = 2'd2;
               j_in = PAGES_W'(idx_ff - IDX_W'(layout.start[2]));
            end
            state_in = ST_AADDR;
         end

         ST_AADDR: begin
            res_addr_in   = layout.base[r_ff] + (PADDR_W'(j_ff) << PAGE_SHIFT);
            res_status_in = STATUS_ALLOCATED;
            state_in      = ST_RESP;
         end

         ST_FMATCH: begin
            // one region per cycle, first match wins
            if (r_ff >= layout.count) begin
               res_status_in = STATUS_FREE_IGNORED;
               state_in      = ST_RESP;
            end else if (diff[PAGE_SHIFT-1:0] == '0 &&
                         diff[PADDR_W-1:PAGE_SHIFT] < OFS_W'(layout.pages[r_ff])) begin
               j_in     = diff[PAGE_SHIFT +: PAGES_W];
               state_in = ST_FIDX;
            end else begin
               r_in = r_ff + 2'd1;
            end
         end

         ST_FIDX: begin
            if (free_idx >= IDX_W'(TOTAL_PAGES)) begin
               res_status_in = STATUS_FREE_IGNORED;
               state_in      = ST_RESP;
            end else begin
               word_in  = free_idx[AW+BIT_W-1:BIT_W];
               bit_in   = free_idx[BIT_W-1:0];
               rd_en    = 1'b1;
               rd_addr  = free_idx[AW+BIT_W-1:BIT_W];
               if (free_idx[AW+BIT_W-1:BIT_W] < hint_ff) begin
                  hint_in = free_idx[AW+BIT_W-1:BIT_W];
               end
               state_in = ST_FWRITE;
            end
         end

         ST_FWRITE: begin
            wr_en         = 1'b1;
            wr_addr       = word_ff;
            wr_data       = rd_data & ~(WORD_W'(1) << bit_ff);
            res_status_in = STATUS_FREED;
            state_in      = ST_RESP;
         end

         ST_RESP: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_address = res_addr_ff;
               rsp_data_in.status         = res_status_ff;
               state_in                   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      r_ff          <= r_in;
      target_ff     <= target_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/tb_bitmap_page_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// tb_bitmap_page_frame_allocator_core
// self-checking bench for the bitmap page frame allocator: a typed table of
// directed requests over hand-picked region layouts, then random layouts with
// alloc/free traffic, frees mostly of pages that are really held, every
// result checked in order against its table answer or a cycle-free model
// of the page bitmap
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator_core;
   import bpfa_pkg::*;

   // block configuration, kept at the defaults of the core
   localparam int TOTAL_PAGES = 4096;
   localparam int PAGE_BYTES  = 4096;

   // register index that decodes to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_IDX = 3'd7;

   // highest page-aligned address, used for layouts that wrap past the top
   localparam logic [PADDR_W-1:0] ADDR_TOP_PAGE = 48'hFFFF_FFFF_F000;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 128;
   localparam int IDLE_PAD        = 8;    // cycles after the last result before a csr write
   localparam int DRAIN_CYCLES    = 150;  // longest alloc scan plus margin

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // dut ports, the inputs known from time zero
   logic            req_valid = 1'b0;
   logic            req_stall;
   bpfa_req_type    req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   bpfa_rsp_type    rsp_data;
   logic            csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bitmap_page_frame_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // allocator model: region registers and one used bit per page number
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0] cfg_count;
   logic [PADDR_W-1:0] cfg_base  [REGION_SLOTS];
   logic [PAGES_W-1:0] cfg_pages [REGION_SLOTS];
   bit                 frame_used [TOTAL_PAGES];

   bpfa_rsp_type       awaited_frames [$];   // results still to come, oldest first
   logic [PADDR_W-1:0] held_frames [$];      // addresses handed out, candidates for free

   // idling pattern shared by both channels; steady phases run gap-free
   bit steady = 1'b0;

   // run statistics
   int unsigned mismatches   = 0;
   int unsigned results_seen = 0;
   int unsigned n_requests   = 0;
   int unsigned n_allocated  = 0;
   int unsigned n_no_free    = 0;
   int unsigned n_freed      = 0;
   int unsigned n_ignored    = 0;
   int unsigned n_layouts    = 0;

   // what the allocator answers to one request, updating the bitmap
   function automatic bpfa_rsp_type page_frame_outcome(input bpfa_req_type item);
      bpfa_rsp_type       outcome;
      int unsigned        first;
      int unsigned        idx;
      int unsigned        r;
      int unsigned        j;
      bit                 done;
      logic [PADDR_W-1:0] offset;
      outcome.result_address = '0;
      first = 0;
      done  = 1'b0;
      if (item.operation == OP_ALLOC) begin
         // lowest page number whose bit is clear, region order
         outcome.status = STATUS_NO_FREE_PAGE;
         for (r = 0; r < cfg_count && !done; r++) begin
            for (j = 0; j < cfg_pages[r] && !done; j++) begin
               if (first + j < TOTAL_PAGES && !frame_used[first + j]) begin
                  frame_used[first + j]  = 1'b1;
                  outcome.result_address = cfg_base[r] + PADDR_W'(j) * PAGE_BYTES;
                  outcome.status         = STATUS_ALLOCATED;
                  done                   = 1'b1;
               end
            end
            first += cfg_pages[r];
         end
      end else begin
         // first page whose address matches, misaligned never matches
         outcome.status = STATUS_FREE_IGNORED;
         if (item.page_address % PAGE_BYTES == 0) begin
            for (r = 0; r < cfg_count && !done; r++) begin
               offset = item.page_address - cfg_base[r];
               if (offset % PAGE_BYTES == 0 && offset / PAGE_BYTES < cfg_pages[r]) begin
                  done = 1'b1;
                  idx  = first + int'(offset / PAGE_BYTES);
                  // pages past the bitmap are never freed
                  if (idx < TOTAL_PAGES) begin
                     frame_used[idx] = 1'b0;
                     outcome.status  = STATUS_FREED;
                  end
               end
               first += cfg_pages[r];
            end
         end
      end
      return outcome;
   endfunction

   function automatic logic [PADDR_W-1:0] random_address();
      return PADDR_W'({$urandom(), $urandom()});
   endfunction

   // mostly back-to-back, some short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // address for a random free: held pages first, then near misses and noise
   function automatic logic [PADDR_W-1:0] pick_free_target();
      int unsigned        roll;
      int unsigned        pick;
      int unsigned        r;
      logic [PADDR_W-1:0] target;
      roll = $urandom_range(0, 99);
      if (roll < 60 && held_frames.size() != 0) begin
         pick   = $urandom_range(0, held_frames.size() - 1);
         target = held_frames[pick];
         held_frames.delete(pick);
      end else if (roll < 75) begin
         // a page of some slot, possibly just past its end or already free
         r      = $urandom_range(0, REGION_SLOTS - 1);
         target = cfg_base[r] + PADDR_W'($urandom_range(0, cfg_pages[r] + 1)) * PAGE_BYTES;
      end else if (roll < 85) begin
         target = random_address();
         target = target - target % PAGE_BYTES + $urandom_range(1, PAGE_BYTES - 1);
      end else if (roll < 95) begin
         target = random_address();
         target = target - target % PAGE_BYTES;
      end else begin
         target = random_address();
      end
      return target;
   endfunction

   // one register write at the next edge; csr_we is left high for a burst
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_REGION_COUNT:   cfg_count    = value[COUNT_W-1:0];
         CSR_REGION_BASE_0:  cfg_base[0]  = value[PADDR_W-1:0];
         CSR_REGION_PAGES_0: cfg_pages[0] = value[PAGES_W-1:0];
         CSR_REGION_BASE_1:  cfg_base[1]  = value[PADDR_W-1:0];
         CSR_REGION_PAGES_1: cfg_pages[1] = value[PAGES_W-1:0];
         CSR_REGION_BASE_2:  cfg_base[2]  = value[PADDR_W-1:0];
         CSR_REGION_PAGES_2: cfg_pages[2] = value[PAGES_W-1:0];
         default: ;
      endcase
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_frames.size() != 0) @(posedge clock);
      repeat (IDLE_PAD) @(posedge clock);
   endtask

   // one request transfer; the model is stepped at the accepting edge
   task automatic send_request(input bpfa_req_type item, input bit typed,
                               input bpfa_rsp_type typed_want);
      int unsigned  gap;
      bpfa_rsp_type outcome;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcome = page_frame_outcome(item);
      // typed rows carry their answer in the table, the model still tracks the bitmap
      awaited_frames.push_back(typed ? typed_want : outcome);
      n_requests++;
      case (outcome.status)
         STATUS_ALLOCATED: begin
            n_allocated++;
            held_frames.push_back(outcome.result_address);
         end
         STATUS_NO_FREE_PAGE: n_no_free++;
         STATUS_FREED:        n_freed++;
         default:             n_ignored++;
      endcase
   endtask

   // random region layout: small regions mostly, some empty, a few full size
   task automatic configure_regions();
      logic [PADDR_W-1:0] base  [REGION_SLOTS];
      logic [PAGES_W-1:0] pages [REGION_SLOTS];
      logic [COUNT_W-1:0] count;
      int unsigned        roll;
      int unsigned        r;
      roll  = $urandom_range(0, 99);
      count = roll < 10 ? 2'd0 : roll < 25 ? 2'd1 : roll < 50 ? 2'd2 : 2'd3;
      for (r = 0; r < REGION_SLOTS; r++) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            pages[r] = '0;
         end else if (roll < 75) begin
            pages[r] = PAGES_W'($urandom_range(1, 24));
         end else if (roll < 90) begin
            pages[r] = PAGES_W'($urandom_range(25, TOTAL_PAGES - 1));
         end else begin
            pages[r] = PAGES_W'(TOTAL_PAGES);
         end
         roll    = $urandom_range(0, 99);
         base[r] = random_address();
         if (roll < 60) begin
            base[r] = base[r] - base[r] % PAGE_BYTES;
         end else if (roll < 75) begin
            // close to the top so page addresses wrap through zero
            base[r] = ADDR_TOP_PAGE - PADDR_W'($urandom_range(0, 8)) * PAGE_BYTES;
         end else if (roll < 90 && r != 0) begin
            // overlaps an earlier slot, first match wins
            base[r] = base[$urandom_range(0, r - 1)];
         end
         // otherwise an unaligned base
      end
      wait_idle();
      write_csr(CSR_REGION_COUNT, CSR_DATA_W'(count));
      for (r = 0; r < REGION_SLOTS; r++) begin
         write_csr(CSR_BASE_IDX[r], base[r]);
         write_csr(CSR_PAGES_IDX[r], CSR_DATA_W'(pages[r]));
      end
      if ($urandom_range(0, 3) == 0) begin
         write_csr(CSR_UNMAPPED_IDX, random_address());
      end
      csr_we <= 1'b0;
      n_layouts++;
   endtask

   // ---------------------------------------------------------------------
   // directed table: csr rows and request rows, walked in order
   // ---------------------------------------------------------------------
   typedef struct {
      bit                     csr_row;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      bpfa_req_type           item;
      bit                     typed;
      bpfa_rsp_type           want;
   } script_row_type;

   script_row_type script [$];

   function automatic void script_csr(input logic [CSR_INDEX_W-1:0] index,
                                      input logic [CSR_DATA_W-1:0]  value);
      script_row_type row;
      row         = '{default: '0};
      row.csr_row = 1'b1;
      row.index   = index;
      row.value   = value;
      script.push_back(row);
   endfunction

   function automatic void script_item(input bpfa_op_type op, input logic [PADDR_W-1:0] addr);
      script_row_type row;
      row                   = '{default: '0};
      row.item.operation    = op;
      row.item.page_address = addr;
      script.push_back(row);
   endfunction

   function automatic void script_typed(input bpfa_op_type op, input logic [PADDR_W-1:0] addr,
                                        input logic [PADDR_W-1:0] want_addr,
                                        input bpfa_status_type want_status);
      script_row_type row;
      row                     = '{default: '0};
      row.item.operation      = op;
      row.item.page_address   = addr;
      row.typed               = 1'b1;
      row.want.result_address = want_addr;
      row.want.status         = want_status;
      script.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // result side: random stall and in-order checking
   // ---------------------------------------------------------------------
   initial begin : rsp_backpressure
      int unsigned hold;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%t mismatch: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin : frame_check
      bpfa_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (awaited_frames.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, address %h status %0d",
                                    rsp_data.result_address, rsp_data.status));
         end else begin
            want = awaited_frames.pop_front();
            if (rsp_data.result_address !== want.result_address) begin
               flag_mismatch($sformatf("result %0d address: expected %h, got %h",
                                       results_seen, want.result_address,
                                       rsp_data.result_address));
            end
            if (rsp_data.status !== want.status) begin
               flag_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                       results_seen, want.status, rsp_data.status));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned  k;
      int unsigned  phase;
      int unsigned  n;
      int unsigned  alloc_pct;
      bit           writing;
      bpfa_req_type item;

      cfg_count = '0;
      for (k = 0; k < REGION_SLOTS; k++) begin
         cfg_base[k]  = '0;
         cfg_pages[k] = '0;
      end

      // reset, then let the clearing pass of the bitmap finish
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (req_stall) @(posedge clock);

      // no regions after reset: nothing to hand out, nothing to match
      script_typed(OP_ALLOC, '0, '0, STATUS_NO_FREE_PAGE);
      script_typed(OP_FREE, '0, '0, STATUS_FREE_IGNORED);

      // two regions of two pages, the second wrapping through address zero;
      // slot two is set up but not counted, the unmapped index must do nothing
      script_csr(CSR_REGION_COUNT, 48'd2);
      script_csr(CSR_REGION_BASE_0, 48'h0000_0001_0000);
      script_csr(CSR_REGION_PAGES_0, 48'd2);
      script_csr(CSR_REGION_BASE_1, ADDR_TOP_PAGE);
      script_csr(CSR_REGION_PAGES_1, 48'd2);
      script_csr(CSR_REGION_BASE_2, 48'h0000_0050_0000);
      script_csr(CSR_REGION_PAGES_2, 48'd5);
      script_csr(CSR_UNMAPPED_IDX, 48'hFFFF_FFFF_FFFF);
      script_typed(OP_ALLOC, '0, 48'h0000_0001_0000, STATUS_ALLOCATED);
      script_typed(OP_ALLOC, '0, 48'h0000_0001_1000, STATUS_ALLOCATED);
      script_typed(OP_ALLOC, 48'hFFFF_FFFF_FFFF, ADDR_TOP_PAGE, STATUS_ALLOCATED);
      script_typed(OP_ALLOC, '0, '0, STATUS_ALLOCATED);          // wrapped page
      script_typed(OP_ALLOC, '0, '0, STATUS_NO_FREE_PAGE);       // all four used
      script_typed(OP_FREE, 48'h0000_0001_0001, '0, STATUS_FREE_IGNORED);  // misaligned
      script_typed(OP_FREE, 48'h0000_0050_0000, '0, STATUS_FREE_IGNORED);  // slot not in use
      script_typed(OP_FREE, 48'h0000_0001_1000, '0, STATUS_FREED);
      script_typed(OP_FREE, 48'h0000_0001_1000, '0, STATUS_FREED);         // already free
      script_typed(OP_ALLOC, '0, 48'h0000_0001_1000, STATUS_ALLOCATED);
      script_typed(OP_FREE, '0, '0, STATUS_FREED);
      script_typed(OP_FREE, 48'hFFFF_FFFF_FFFF, '0, STATUS_FREE_IGNORED);
      script_typed(OP_ALLOC, '0, '0, STATUS_ALLOCATED);
      script_typed(OP_FREE, ADDR_TOP_PAGE, '0, STATUS_FREED);

      // empty region zero, full-size region one, unaligned top base in region two
      // whose pages all fall past the bitmap
      script_csr(CSR_REGION_COUNT, 48'd3);
      script_csr(CSR_REGION_BASE_0, 48'h0000_0000_7000);
      script_csr(CSR_REGION_PAGES_0, 48'd0);
      script_csr(CSR_REGION_BASE_1, 48'h0000_0100_0000);
      script_csr(CSR_REGION_PAGES_1, 48'd4096);
      script_csr(CSR_REGION_BASE_2, 48'hFFFF_FFFF_FFFF);
      script_csr(CSR_REGION_PAGES_2, 48'd4096);
      script_typed(OP_FREE, 48'h0000_0000_7000, '0, STATUS_FREE_IGNORED);
      script_item(OP_ALLOC, '0);
      script_item(OP_ALLOC, '0);
      script_item(OP_FREE, 48'h0000_01FF_F000);                  // last page of the bitmap
      script_typed(OP_FREE, 48'h0000_0200_0000, '0, STATUS_FREE_IGNORED);  // one past the end

      // region one sits beyond the bitmap, region two overlaps region zero
      script_csr(CSR_REGION_BASE_0, 48'h0000_0000_0000);
      script_csr(CSR_REGION_PAGES_0, 48'd4096);
      script_csr(CSR_REGION_BASE_1, 48'h0000_1000_0000);
      script_csr(CSR_REGION_PAGES_1, 48'd1);
      script_csr(CSR_REGION_BASE_2, 48'h0000_0000_0000);
      script_typed(OP_FREE, 48'h0000_1000_0000, '0, STATUS_FREE_IGNORED);
      script_typed(OP_FREE, '0, '0, STATUS_FREED);
      script_typed(OP_ALLOC, '0, '0, STATUS_ALLOCATED);
      script_item(OP_FREE, 48'h0000_00FF_F000);

      writing = 1'b0;
      for (k = 0; k < script.size(); k++) begin
         if (script[k].csr_row) begin
            if (!writing) begin
               wait_idle();
            end
            writing = 1'b1;
            write_csr(script[k].index, script[k].value);
         end else begin
            if (writing) begin
               csr_we <= 1'b0;
               n_layouts++;
            end
            writing = 1'b0;
            send_request(script[k].item, script[k].typed, script[k].want);
         end
      end

      // random layouts, each with a burst of mixed traffic
      for (phase = 0; phase < PHASES; phase++) begin
         configure_regions();
         steady    = ($urandom_range(0, 4) == 0);
         alloc_pct = $urandom_range(25, 75);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
               item.operation    = OP_ALLOC;
               item.page_address = random_address();  // don't care for alloc
            end else begin
               item.operation    = OP_FREE;
               item.page_address = pick_free_target();
            end
            send_request(item, 1'b0, '0);
         end
      end
      steady = 1'b0;

      // drain and settle
      req_valid <= 1'b0;
      while (awaited_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over %0d region layouts, %0d results checked",
               n_requests, n_layouts, results_seen);
      $display("allocated %0d, no free page %0d, freed %0d, ignored %0d, mismatches %0d",
               n_allocated, n_no_free, n_freed, n_ignored, mismatches);
      if (mismatches == 0) begin
         $display("** bitmap_page_frame_allocator_core: PASSED **");
      end else begin
         $display("** bitmap_page_frame_allocator_core: FAILED **");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #(25_000_000);
      $display("timeout with %0d results outstanding", awaited_frames.size());
      $display("** bitmap_page_frame_allocator_core: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/bpfa_pkg.sv
hdl/bpfa_ram.sv
hdl/bpfa_csr.sv
hdl/bpfa_find.sv
hdl/bitmap_page_frame_allocator_core.sv
tb/tb_bitmap_page_frame_allocator_core.sv
